// ===== rtl/core/mpd_pkg.sv =====
package mpd_pkg;

  localparam int NUM_PINS = 3;
  localparam int TICK_W   = 8;
  localparam int CFG_W    = (NUM_PINS > TICK_W) ? NUM_PINS : TICK_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [TICK_W-1:0] DEFAULT_TICKS = TICK_W'(10);

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = CFG_IDX_W'(1);

  typedef logic [NUM_PINS-1:0] pin_vec_t;

  // Shared per-pin controls from the top level
  typedef struct packed {
    logic step;     // an item moves through the work stage this cycle
    logic started;  // an item has already gone through since reset
    logic tick;     // tick flag of the item in the work stage
    logic commit;   // enable-mask write: settle pending pins silently
  } pin_ctrl_t;

endpackage

// ===== rtl/core/mpd_pin.sv =====
module mpd_pin (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mpd_pkg::pin_ctrl_t         ctrl,
  input  logic                       deb_en,
  input  logic                       pin_level,
  input  logic [mpd_pkg::TICK_W-1:0] ticks_load,
  output logic                       stable_nxt,
  output logic                       changed,
  output logic                       pending_nxt
);
  import mpd_pkg::*;

  logic              stable_r;
  logic              trans_r;
  logic [TICK_W-1:0] cnt_r;
  logic [TICK_W-1:0] cnt_nxt;

  always_comb begin
    stable_nxt  = stable_r;
    pending_nxt = trans_r;
    cnt_nxt     = cnt_r;
    changed     = 1'b0;
    if (ctrl.commit) begin
      if (trans_r) begin
        stable_nxt  = ~stable_r;
        pending_nxt = 1'b0;
        cnt_nxt     = '0;
      end
    end else if (ctrl.step) begin
      if (!ctrl.started) begin
        stable_nxt  = pin_level;
        pending_nxt = 1'b0;
        cnt_nxt     = '0;
      end else if (!deb_en) begin
        if (pin_level != stable_r) begin
          stable_nxt = pin_level;
          changed    = 1'b1;
        end
      end else if (!trans_r) begin
        if (pin_level != stable_r) begin
          pending_nxt = 1'b1;
          cnt_nxt     = ticks_load;
        end
      end else if (pin_level == stable_r) begin
        // raw level came back before expiry: cancel
        pending_nxt = 1'b0;
        cnt_nxt     = '0;
      end else if (ctrl.tick) begin
        if (cnt_r > TICK_W'(1)) begin
          cnt_nxt = cnt_r - TICK_W'(1);
        end else begin
          cnt_nxt     = '0;
          pending_nxt = 1'b0;
          stable_nxt  = pin_level;
          changed     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      trans_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      stable_r <= stable_nxt;
      trans_r  <= pending_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/multi_pin_debouncer_unit.sv =====
// Multi-pin switch debouncer.
// Input channel: in_valid/in_stall with in_pin_levels (raw level per pin) and
// in_tick (one millisecond has passed with this item). Result channel:
// out_valid/out_stall with out_stable_levels, out_changed and out_pending.
// Every input item gives exactly one result.
// Pipeline: an accepted item passes through one input register and then one
// result register; a stall on the result channel holds it in the input
// register. Throughput: one item per clock while the receiver does not stall;
// the per-pin update is combinational logic between the two registers.
// The first item after reset loads the stable levels and reports no change.
// Configuration: cfg_we/cfg_index/cfg_wdata; index 0 is the debounce enable
// mask (writing it settles pending pins silently), index 1 the tick count
// (0 acts as 1). Write only while the block is idle.
// Reset (rst_n low, synchronous) empties both registers, clears all pin state
// and loads the enable mask with all ones and the tick count with 10.
// When the receiver stalls, the result holds; the input register still takes
// one more item, then in_stall rises until the result is taken.
module multi_pin_debouncer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mpd_pkg::NUM_PINS-1:0]  in_pin_levels,
  input  logic                          in_tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mpd_pkg::NUM_PINS-1:0]  out_stable_levels,
  output logic [mpd_pkg::NUM_PINS-1:0]  out_changed,
  output logic [mpd_pkg::NUM_PINS-1:0]  out_pending,
  input  logic                          cfg_we,
  input  logic [mpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpd_pkg::CFG_W-1:0]     cfg_wdata
);
  import mpd_pkg::*;

  logic              in_v_r;
  pin_vec_t          pins_r;
  logic              tick_r;
  logic              out_v_r;
  pin_vec_t          stable_out_r;
  pin_vec_t          changed_out_r;
  pin_vec_t          pending_out_r;
  pin_vec_t          enable_r;
  logic [TICK_W-1:0] ticks_r;
  logic              started_r;

  logic              step;
  logic              in_take;
  logic [TICK_W-1:0] ticks_load;
  pin_ctrl_t         ctrl;
  pin_vec_t          stable_nxt;
  pin_vec_t          changed_nxt;
  pin_vec_t          pending_nxt;

  assign step     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !step;
  assign in_take  = in_valid && !in_stall;

  assign ticks_load = (ticks_r == '0) ? TICK_W'(1) : ticks_r;

  assign ctrl.step    = step;
  assign ctrl.started = started_r;
  assign ctrl.tick    = tick_r;
  assign ctrl.commit  = cfg_we && (cfg_index == REG_DEBOUNCE_ENABLE);

  for (genvar i = 0; i < NUM_PINS; i++) begin : g_pin
    mpd_pin u_pin (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .deb_en     (enable_r[i]),
      .pin_level  (pins_r[i]),
      .ticks_load (ticks_load),
      .stable_nxt (stable_nxt[i]),
      .changed    (changed_nxt[i]),
      .pending_nxt(pending_nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      started_r <= 1'b0;
      enable_r  <= '1;
      ticks_r   <= DEFAULT_TICKS;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (step) begin
        in_v_r <= 1'b0;
      end
      if (step) begin
        out_v_r   <= 1'b1;
        started_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEBOUNCE_ENABLE: enable_r <= cfg_wdata[NUM_PINS-1:0];
          REG_DEBOUNCE_TICKS:  ticks_r  <= cfg_wdata[TICK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pins_r <= in_pin_levels;
      tick_r <= in_tick;
    end
    if (step) begin
      stable_out_r  <= stable_nxt;
      changed_out_r <= changed_nxt;
      pending_out_r <= pending_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_stable_levels = stable_out_r;
  assign out_changed       = changed_out_r;
  assign out_pending       = pending_out_r;

endmodule
